FILE: rtl/core/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_DELAY = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DOUBLE_WINDOW  = 2'd2;

  // Register reset values (ms)
  localparam logic [CfgDataW-1:0] RST_DEBOUNCE_DELAY = 16'd50;
  localparam logic [CfgDataW-1:0] RST_LONG_PRESS     = 16'd1000;
  localparam logic [CfgDataW-1:0] RST_DOUBLE_WINDOW  = 16'd300;

  // Width of the timestamp field
  localparam int unsigned NowW = 32;

  // Click classification codes
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } click_e;

  // Timing configuration handed to the classifier
  typedef struct packed {
    logic [CfgDataW-1:0] debounce_delay;
    logic [CfgDataW-1:0] long_press_time;
    logic [CfgDataW-1:0] double_click_window;
  } cfg_t;

endpackage

FILE: rtl/core/bcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bcc_cfg_regs
// Timing configuration registers; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module bcc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [bcc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bcc_pkg::CfgDataW-1:0]   cfg_data_i,
  output logic                           cfg_ready_o,
  output bcc_pkg::cfg_t                  cfg_o
);
  import bcc_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Register file is always writable
  assign cfg_ready_o = 1'b1;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DEBOUNCE_DELAY: cfg_d.debounce_delay      = cfg_data_i;
        REG_LONG_PRESS:     cfg_d.long_press_time     = cfg_data_i;
        REG_DOUBLE_WINDOW:  cfg_d.double_click_window = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_delay      <= RST_DEBOUNCE_DELAY;
      cfg_q.long_press_time     <= RST_LONG_PRESS;
      cfg_q.double_click_window <= RST_DOUBLE_WINDOW;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/bcc_classify.sv
// ----------------------------------------------------------------------------
// bcc_classify
// Debounce and click state; classifies one poll per enabled cycle.
// ----------------------------------------------------------------------------
module bcc_classify #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   raw_i,
  input  logic [TIME_WIDTH-1:0]  now_i,
  input  bcc_pkg::cfg_t          cfg_i,
  output bcc_pkg::click_e        event_o
);
  import bcc_pkg::*;

  logic                  last_raw_q, last_raw_d;
  logic                  pressed_q, pressed_d;
  logic                  awaiting_q, awaiting_d;
  logic [TIME_WIDTH-1:0] change_time_q, change_time_d;
  logic [TIME_WIDTH-1:0] press_start_q, press_start_d;
  logic [TIME_WIDTH-1:0] release_time_q, release_time_d;

  logic [TIME_WIDTH-1:0] stable_for, held_for, since_release;
  logic [TIME_WIDTH-1:0] dbnc_w, long_w, dwin_w;
  logic                  stable, press, release_ev;
  logic                  is_long, is_double, arm, is_short, aw_mid;

  // Config values widened to the time width
  assign dbnc_w = TIME_WIDTH'(cfg_i.debounce_delay);
  assign long_w = TIME_WIDTH'(cfg_i.long_press_time);
  assign dwin_w = TIME_WIDTH'(cfg_i.double_click_window);

  // Debounce: a level change restarts the stability timer
  assign last_raw_d    = raw_i;
  assign change_time_d = (raw_i != last_raw_q) ? now_i : change_time_q;
  assign stable_for    = now_i - change_time_d;
  assign stable        = stable_for > dbnc_w;
  assign press         = stable &&  raw_i && !pressed_q;
  assign release_ev    = stable && !raw_i &&  pressed_q;

  // Release classification
  assign held_for  = now_i - press_start_q;
  assign is_long   = release_ev && (held_for >= long_w);
  assign is_double = release_ev && !is_long && awaiting_q;
  assign arm       = release_ev && !is_long && !awaiting_q;

  // Second-click timeout; a release on this poll either reports or arms
  // (zero elapsed), so only a wait armed earlier can run out
  assign aw_mid         = arm | awaiting_q;
  assign release_time_d = arm ? now_i : release_time_q;
  assign since_release  = now_i - release_time_q;
  assign is_short       = awaiting_q && !release_ev && (since_release > dwin_w);

  assign awaiting_d    = (is_long || is_double || is_short) ? 1'b0 : aw_mid;
  assign press_start_d = press ? now_i : press_start_q;

  always_comb begin
    pressed_d = pressed_q;
    if (press)      pressed_d = 1'b1;
    if (release_ev) pressed_d = 1'b0;
  end

  // Event encode
  always_comb begin
    if (is_long)        event_o = EV_LONG;
    else if (is_double) event_o = EV_DOUBLE;
    else if (is_short)  event_o = EV_SHORT;
    else                event_o = EV_NONE;
  end

  // State update, one poll per step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q     <= 1'b0;
      pressed_q      <= 1'b0;
      awaiting_q     <= 1'b0;
      change_time_q  <= '0;
      press_start_q  <= '0;
      release_time_q <= '0;
    end else if (step_i) begin
      last_raw_q     <= last_raw_d;
      pressed_q      <= pressed_d;
      awaiting_q     <= awaiting_d;
      change_time_q  <= change_time_d;
      press_start_q  <= press_start_d;
      release_time_q <= release_time_d;
    end
  end

endmodule

FILE: rtl/core/button_click_classifier.sv
// ----------------------------------------------------------------------------
// button_click_classifier
// Debounced push-button click classifier (short, double and long clicks).
// ----------------------------------------------------------------------------
// Each input beat is one poll of the button (raw level plus a free-running ms
// timestamp) and yields exactly one output beat carrying a click code (none,
// short, double or long). A poll is captured in an input register, classified
// against the debounce and click state once the result register can take it,
// and lands in the output register; one poll is taken every cycle while the
// output is not stalled. While the output beat is stalled one more poll is
// still taken into the input register. Timing registers are written through
// the config port by the user only while the block is idle; the block itself
// does not enforce this. Writes to unknown indexes are ignored.
// ----------------------------------------------------------------------------
module button_click_classifier #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // poll channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          raw_level_i,
  input  logic [bcc_pkg::NowW-1:0]      now_ms_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    click_event_o,
  // config channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bcc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bcc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bcc_pkg::*;

  cfg_t                  cfg;
  click_e                event_c;
  logic                  s1_valid_q, s1_valid_d;
  logic                  s1_raw_q;
  logic [TIME_WIDTH-1:0] s1_now_q, now_t;
  logic                  s2_valid_q, s2_valid_d;
  logic [1:0]            s2_event_q;
  logic                  s2_ready, s1_fire, in_fire;

  // Timestamp cut or zero-extended to the internal time width
  if (TIME_WIDTH <= NowW) begin : g_now_cut
    assign now_t = now_ms_i[TIME_WIDTH-1:0];
  end else begin : g_now_ext
    assign now_t = {{(TIME_WIDTH-NowW){1'b0}}, now_ms_i};
  end

  // Handshake
  assign s2_ready   = !s2_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && s2_ready;
  assign in_stall_o = s1_valid_q && !s2_ready;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_fire || (s1_valid_q && !s1_fire);
  assign s2_valid_d = s1_fire || (s2_valid_q && !s2_ready);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_raw_q <= raw_level_i;
      s1_now_q <= now_t;
    end
  end

  // Config registers
  bcc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  // Classifier
  bcc_classify #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_fire),
    .raw_i   (s1_raw_q),
    .now_i   (s1_now_q),
    .cfg_i   (cfg),
    .event_o (event_c)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      s2_event_q <= event_c;
    end
  end

  assign out_valid_o   = s2_valid_q;
  assign click_event_o = s2_event_q;

endmodule

FILE: rtl/core/bcc_checker.sv
// ----------------------------------------------------------------------------
// bcc_checker
// Port-level checks for the button click classifier, bound to the top level.
// ----------------------------------------------------------------------------
module bcc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] click_event_o
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(click_event_o))
    else $error("stalled result beat changed");

  // Input stalls only when the result register is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free output");

  // Every accepted poll shows up at the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##2 out_valid_o)
    else $error("result missing after accepted poll");

  // No result appears without an earlier accepted poll
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result beat without poll");

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (.*);
